### rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Table geometry, field widths, request and status codes, table entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int ADDR_W       = 20;
    localparam int SIZE_W       = 20;
    localparam int LIMIT_W      = ADDR_W + 1;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 2);
    localparam int HEADER_BYTES = 24;

    typedef logic [ADDR_W:0]   t_daddr;   // start plus header, one carry bit
    typedef logic [ADDR_W+1:0] t_newtop;  // top plus header plus size
    typedef logic [LIMIT_W-1:0] t_limit;

    localparam t_daddr HDR_DADDR  = t_daddr'(HEADER_BYTES);
    localparam t_newtop HDR_NEWTOP = t_newtop'(HEADER_BYTES);
    localparam t_limit LIMIT_CAP  = t_limit'(1) << ADDR_W;
    localparam t_limit LIMIT_RST  = t_limit'(1) << ADDR_W;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_REALLOC = 2'd2,
        KIND_IGNORE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FAIL    = 2'd1,
        STAT_UNKNOWN = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE_OLD,
        ST_FINISH
    } t_state;

    typedef enum logic {
        MODE_FIND,
        MODE_FIT
    } t_mode;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              free;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

### rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit heap block table with a scan sequencer
//
// Request channel (i_valid/o_ready) carries one item: kind (allocate, free,
// reallocate), a payload size and a data address. Result channel
// (o_valid/i_ready) returns exactly one item per request: the data address,
// a status code, a moved flag and the byte count to copy.
// Configuration channel (i_cfg_valid/o_cfg_ready) writes heap_limit; it is
// always ready and should be used only while no request is in flight.
//
// Timing: the block table lives in a RAM with a registered read port, and one
// shared compare unit walks it one entry per cycle, pipelined with the read.
// A request runs one scan pass over the N blocks in the table, then the write
// and finish; a reallocate that must move runs two passes. Zero-size allocates,
// null frees and the ignored kind skip the scan and go straight to finish.
// One request is in work at a time, and o_ready is high only while the
// sequencer is idle.
// The result sits in an output register, so the next request may be accepted
// while the previous result is still stalled; a finished result then waits in
// the sequencer until the output register frees up.
// Reset: the table is empty, the heap top is zero and heap_limit is 2^20.
// Table contents are not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request channel
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [1:0]                   i_kind,
    input  wire logic [ffba_pkg::SIZE_W-1:0]  i_size,
    input  wire logic [ffba_pkg::ADDR_W-1:0]  i_address,
    // result channel
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [ffba_pkg::ADDR_W-1:0]       o_address_res,
    output logic [1:0]                        o_status,
    output logic                              o_moved,
    output logic [ffba_pkg::SIZE_W-1:0]       o_copy_bytes,
    // configuration channel (heap_limit)
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [ffba_pkg::LIMIT_W-1:0] i_cfg_data
);

    // sequencer and request
    ffba_pkg::t_state               r_state, n_state;
    ffba_pkg::t_mode                r_mode, n_mode;
    ffba_pkg::t_kind                r_kind, n_kind;
    logic [ffba_pkg::SIZE_W-1:0]    r_size, n_size;
    logic [ffba_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic                           r_move, n_move;

    // scan pipeline: r_idx is the address being read, r_cidx the one checked
    logic [ffba_pkg::CNT_W-1:0]     r_idx, n_idx;
    logic [ffba_pkg::IDX_W-1:0]     r_cidx, n_cidx;
    logic                           r_pend, n_pend;

    // old block of a moving reallocate
    logic [ffba_pkg::IDX_W-1:0]     r_old_idx, n_old_idx;
    ffba_pkg::t_entry               r_old_word, n_old_word;

    // heap state
    logic [ffba_pkg::CNT_W-1:0]     r_count, n_count;
    ffba_pkg::t_limit               r_top, n_top;
    ffba_pkg::t_limit               r_limit, n_limit;

    // result being built
    logic [ffba_pkg::ADDR_W-1:0]    r_res_addr, n_res_addr;
    ffba_pkg::t_status              r_res_status, n_res_status;
    logic                           r_res_moved, n_res_moved;
    logic [ffba_pkg::SIZE_W-1:0]    r_res_copy, n_res_copy;

    // output register
    logic                           r_out_valid, n_out_valid;
    logic [ffba_pkg::ADDR_W-1:0]    r_out_addr, n_out_addr;
    ffba_pkg::t_status              r_out_status, n_out_status;
    logic                           r_out_moved, n_out_moved;
    logic [ffba_pkg::SIZE_W-1:0]    r_out_copy, n_out_copy;

    // table RAM
    logic                           w_we;
    logic [ffba_pkg::IDX_W-1:0]     w_waddr;
    ffba_pkg::t_entry               w_wdata;
    ffba_pkg::t_entry               w_rdata;
    logic [ffba_pkg::ENTRY_W-1:0]   w_rdata_raw;

    // shared compare unit and append arithmetic
    ffba_pkg::t_daddr               w_daddr;
    logic                           w_hit;
    ffba_pkg::t_newtop              w_new_top;
    ffba_pkg::t_limit               w_eff_limit;
    logic                           w_can_append;
    logic                           w_accept;

    ffba_ram #(
        .WIDTH (ffba_pkg::ENTRY_W),
        .DEPTH (ffba_pkg::MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[ffba_pkg::IDX_W-1:0]),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata = ffba_pkg::t_entry'(w_rdata_raw);

    // Compare the checked entry: data address match or first fit.
    assign w_daddr = {1'b0, w_rdata.start} + ffba_pkg::HDR_DADDR;
    always_comb begin
        unique case (r_mode)
            ffba_pkg::MODE_FIND: w_hit = r_pend && (w_daddr == {1'b0, r_addr});
            ffba_pkg::MODE_FIT:  w_hit = r_pend && w_rdata.free && (w_rdata.size >= r_size);
            default:             w_hit = 1'b0;
        endcase
    end

    // Append check: room in the table and the new top within the limit.
    assign w_eff_limit  = (r_limit > ffba_pkg::LIMIT_CAP) ? ffba_pkg::LIMIT_CAP : r_limit;
    assign w_new_top    = {1'b0, r_top} + ffba_pkg::HDR_NEWTOP
                        + {{(ffba_pkg::LIMIT_W+1-ffba_pkg::SIZE_W){1'b0}}, r_size};
    assign w_can_append = (r_count < ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
                        && (w_new_top <= {1'b0, w_eff_limit});

    assign o_ready     = (r_state == ffba_pkg::ST_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    assign o_valid       = r_out_valid;
    assign o_address_res = r_out_addr;
    assign o_status      = r_out_status;
    assign o_moved       = r_out_moved;
    assign o_copy_bytes  = r_out_copy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffba_pkg::ST_IDLE;
            r_count     <= '0;
            r_top       <= '0;
            r_limit     <= ffba_pkg::LIMIT_RST;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_top       <= n_top;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
        r_mode       <= n_mode;
        r_kind       <= n_kind;
        r_size       <= n_size;
        r_addr       <= n_addr;
        r_move       <= n_move;
        r_idx        <= n_idx;
        r_cidx       <= n_cidx;
        r_old_idx    <= n_old_idx;
        r_old_word   <= n_old_word;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_res_moved  <= n_res_moved;
        r_res_copy   <= n_res_copy;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
        r_out_moved  <= n_out_moved;
        r_out_copy   <= n_out_copy;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_kind       = r_kind;
        n_size       = r_size;
        n_addr       = r_addr;
        n_move       = r_move;
        n_idx        = r_idx;
        n_cidx       = r_cidx;
        n_pend       = 1'b0;
        n_old_idx    = r_old_idx;
        n_old_word   = r_old_word;
        n_count      = r_count;
        n_top        = r_top;
        n_limit      = r_limit;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_res_moved  = r_res_moved;
        n_res_copy   = r_res_copy;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        n_out_moved  = r_out_moved;
        n_out_copy   = r_out_copy;
        w_we         = 1'b0;
        w_waddr      = r_cidx;
        w_wdata      = w_rdata;

        if (i_cfg_valid) begin
            n_limit = i_cfg_data;
        end

        unique case (r_state)
            ffba_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_kind       = ffba_pkg::t_kind'(i_kind);
                    n_size       = i_size;
                    n_addr       = i_address;
                    n_move       = 1'b0;
                    n_idx        = '0;
                    n_res_addr   = '0;
                    n_res_status = ffba_pkg::STAT_OK;
                    n_res_moved  = 1'b0;
                    n_res_copy   = '0;
                    n_state      = ffba_pkg::ST_FINISH;
                    unique case (ffba_pkg::t_kind'(i_kind))
                        ffba_pkg::KIND_ALLOC: begin
                            if (i_size == '0) begin
                                n_res_status = ffba_pkg::STAT_FAIL;
                            end else begin
                                n_mode  = ffba_pkg::MODE_FIT;
                                n_state = ffba_pkg::ST_SCAN;
                            end
                        end
                        ffba_pkg::KIND_FREE: begin
                            // null free is a no-op
                            if (i_address != '0) begin
                                n_mode  = ffba_pkg::MODE_FIND;
                                n_state = ffba_pkg::ST_SCAN;
                            end
                        end
                        ffba_pkg::KIND_REALLOC: begin
                            // null reallocate behaves as an allocate
                            if (i_address != '0) begin
                                n_mode  = ffba_pkg::MODE_FIND;
                                n_state = ffba_pkg::ST_SCAN;
                            end else if (i_size == '0) begin
                                n_res_status = ffba_pkg::STAT_FAIL;
                            end else begin
                                n_mode  = ffba_pkg::MODE_FIT;
                                n_state = ffba_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            // ignored kind: all-zero result
                        end
                    endcase
                end
            end

            ffba_pkg::ST_SCAN: begin
                // advance the read one entry; the checked entry trails by one
                n_pend = (r_idx < r_count);
                n_cidx = r_idx[ffba_pkg::IDX_W-1:0];
                n_idx  = r_idx + 1'b1;

                priority if (w_hit && r_mode == ffba_pkg::MODE_FIND) begin
                    n_old_idx  = r_cidx;
                    n_old_word = w_rdata;
                    n_pend     = 1'b0;
                    if (r_kind == ffba_pkg::KIND_FREE) begin
                        w_we          = 1'b1;
                        w_waddr       = r_cidx;
                        w_wdata       = w_rdata;
                        w_wdata.free  = 1'b1;
                        n_state       = ffba_pkg::ST_FINISH;
                    end else if (w_rdata.size >= r_size) begin
                        // large enough: keep the block in place
                        n_res_addr = r_addr;
                        n_state    = ffba_pkg::ST_FINISH;
                    end else begin
                        // restart the walk as a first-fit search
                        n_mode = ffba_pkg::MODE_FIT;
                        n_move = 1'b1;
                        n_idx  = '0;
                    end
                end else if (w_hit) begin
                    // first fit: take the whole block, never split
                    w_we         = 1'b1;
                    w_waddr      = r_cidx;
                    w_wdata      = w_rdata;
                    w_wdata.free = 1'b0;
                    n_res_addr   = w_daddr[ffba_pkg::ADDR_W-1:0];
                    n_pend       = 1'b0;
                    n_state      = r_move ? ffba_pkg::ST_FREE_OLD : ffba_pkg::ST_FINISH;
                end else if (!r_pend && r_idx >= r_count) begin
                    n_state = ffba_pkg::ST_FINISH;
                    if (r_mode == ffba_pkg::MODE_FIND) begin
                        n_res_status = ffba_pkg::STAT_UNKNOWN;
                    end else if (w_can_append) begin
                        // append a new block at the heap top
                        w_we          = 1'b1;
                        w_waddr       = r_count[ffba_pkg::IDX_W-1:0];
                        w_wdata.start = r_top[ffba_pkg::ADDR_W-1:0];
                        w_wdata.size  = r_size;
                        w_wdata.free  = 1'b0;
                        n_count       = r_count + 1'b1;
                        n_top         = w_new_top[ffba_pkg::LIMIT_W-1:0];
                        n_res_addr    = r_top[ffba_pkg::ADDR_W-1:0]
                                      + ffba_pkg::HDR_DADDR[ffba_pkg::ADDR_W-1:0];
                        if (r_move) begin
                            n_state = ffba_pkg::ST_FREE_OLD;
                        end
                    end else begin
                        // no room: fail and keep any old block
                        n_res_status = ffba_pkg::STAT_FAIL;
                    end
                end else begin
                    // keep walking
                end
            end

            ffba_pkg::ST_FREE_OLD: begin
                w_we         = 1'b1;
                w_waddr      = r_old_idx;
                w_wdata      = r_old_word;
                w_wdata.free = 1'b1;
                n_res_moved  = 1'b1;
                n_res_copy   = r_old_word.size;
                n_state      = ffba_pkg::ST_FINISH;
            end

            ffba_pkg::ST_FINISH: begin
                // hold the result until the output register frees up
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                    n_out_moved  = r_res_moved;
                    n_out_copy   = r_res_copy;
                    n_state      = ffba_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = ffba_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### verif/ffba_heap_tracker.sv
// ----------------------------------------------------------------------------
// ffba_heap_tracker: heap table predictor and result comparator
// Watches the request, result and heap_limit channels of the first-fit block
// allocator. It keeps its own copy of the block table and heap top, works out
// the result of every accepted request, and compares each returned item with
// the oldest pending one.
// ----------------------------------------------------------------------------
module ffba_heap_tracker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_req_valid,
    input  wire logic                         i_req_ready,
    input  wire logic [1:0]                   i_req_kind,
    input  wire logic [ffba_pkg::SIZE_W-1:0]  i_req_size,
    input  wire logic [ffba_pkg::ADDR_W-1:0]  i_req_address,
    input  wire logic                         i_res_valid,
    input  wire logic                         i_res_ready,
    input  wire logic [ffba_pkg::ADDR_W-1:0]  i_res_address,
    input  wire logic [1:0]                   i_res_status,
    input  wire logic                         i_res_moved,
    input  wire logic [ffba_pkg::SIZE_W-1:0]  i_res_copy_bytes,
    input  wire logic                         i_cfg_valid,
    input  wire logic                         i_cfg_ready,
    input  wire logic [ffba_pkg::LIMIT_W-1:0] i_cfg_data,
    output int                                o_outstanding,
    output int                                o_failures
);
    import ffba_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] address_res;
        t_status           status;
        logic              moved;
        logic [SIZE_W-1:0] copy_bytes;
    } t_grant;

    logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
    logic [SIZE_W-1:0] blk_size  [MAX_BLOCKS];
    logic              blk_free  [MAX_BLOCKS];
    int                blk_count;
    logic [ADDR_W+1:0] heap_top;
    t_limit            heap_limit;
    t_grant            grants_due [$];
    int                mismatch_tally;

    // First free block that is large enough, else grow the heap; 0 on failure.
    function automatic logic [ADDR_W-1:0] first_fit(input logic [SIZE_W-1:0] size);
        int                hit;
        t_limit            cap;
        logic [ADDR_W+1:0] grown;
        logic [ADDR_W-1:0] data_addr;
        hit = -1;
        data_addr = '0;
        if (size == 0) begin
            return '0;
        end
        for (int i = 0; i < blk_count; i++) begin
            if (hit < 0 && blk_free[i] && blk_size[i] >= size) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            blk_free[hit] = 1'b0;
            data_addr = blk_start[hit] + ADDR_W'(HEADER_BYTES);
            return data_addr;
        end
        if (blk_count >= MAX_BLOCKS) begin
            return '0;
        end
        cap = (heap_limit > LIMIT_CAP) ? LIMIT_CAP : heap_limit;
        grown = heap_top + (ADDR_W+2)'(HEADER_BYTES) + (ADDR_W+2)'(size);
        if (grown > cap) begin
            return '0;
        end
        blk_start[blk_count] = heap_top[ADDR_W-1:0];
        blk_size[blk_count]  = size;
        blk_free[blk_count]  = 1'b0;
        blk_count++;
        data_addr = heap_top[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
        heap_top = grown;
        return data_addr;
    endfunction

    function automatic int block_at(input logic [ADDR_W-1:0] addr);
        for (int i = 0; i < blk_count; i++) begin
            if (blk_start[i] + HEADER_BYTES == addr) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_grant serve_request(input t_kind kind, input logic [SIZE_W-1:0] size,
                                             input logic [ADDR_W-1:0] addr);
        t_grant g;
        int     idx;
        g = '0;
        g.status = STAT_OK;
        if (kind == KIND_ALLOC || (kind == KIND_REALLOC && addr == 0)) begin
            g.address_res = first_fit(size);
            if (g.address_res == 0) begin
                g.status = STAT_FAIL;
            end
        end else if (kind == KIND_FREE) begin
            if (addr != 0) begin
                idx = block_at(addr);
                if (idx < 0) begin
                    g.status = STAT_UNKNOWN;
                end else begin
                    blk_free[idx] = 1'b1;
                end
            end
        end else if (kind == KIND_REALLOC) begin
            idx = block_at(addr);
            if (idx < 0) begin
                g.status = STAT_UNKNOWN;
            end else if (blk_size[idx] >= size) begin
                g.address_res = addr;
            end else begin
                g.address_res = first_fit(size);
                if (g.address_res == 0) begin
                    g.status = STAT_FAIL;
                end else begin
                    g.moved = 1'b1;
                    g.copy_bytes = blk_size[idx];
                    blk_free[idx] = 1'b1;
                end
            end
        end
        return g;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatch_tally++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_grant want;
        if (!i_rst_n) begin
            blk_count = 0;
            heap_top = '0;
            heap_limit = LIMIT_RST;
            grants_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                heap_limit = i_cfg_data;
            end
            if (i_res_valid && i_res_ready) begin
                if (grants_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got address %0d status %0d",
                             $time, i_res_address, i_res_status);
                    mismatch_tally++;
                end else begin
                    want = grants_due.pop_front();
                    compare_field("address_res", 32'(want.address_res), 32'(i_res_address));
                    compare_field("status", 32'(want.status), 32'(i_res_status));
                    compare_field("moved", 32'(want.moved), 32'(i_res_moved));
                    compare_field("copy_bytes", 32'(want.copy_bytes), 32'(i_res_copy_bytes));
                end
            end
            if (i_req_valid && i_req_ready) begin
                grants_due.push_back(serve_request(t_kind'(i_req_kind), i_req_size,
                                                   i_req_address));
            end
        end
        o_outstanding <= grants_due.size();
        o_failures <= mismatch_tally;
    end

endmodule

### verif/first_fit_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb: randomized test of the first-fit allocator
// Drives allocate, free and reallocate requests through the valid/ready
// channel, stalls the result channel at random, and steps heap_limit through
// several settings while the block is idle. The heap tracker predicts every
// result and counts mismatches; this top gives the verdict.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;
    import ffba_pkg::*;

    // Allow about five times the slowest run: ~560 items, each up to two table
    // passes plus the longest sender gap and result stall.
    localparam int RUN_LIMIT  = 5_000_000;
    localparam int DRAIN_WAIT = 20;
    // Data addresses of the first two blocks appended to an empty heap when
    // the first holds one byte: header after start 0, then header after 25.
    localparam logic [ADDR_W-1:0] FIRST_DATA  = ADDR_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] SECOND_DATA = ADDR_W'(2 * HEADER_BYTES + 1);

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [1:0]          req_kind = KIND_ALLOC;
    logic [SIZE_W-1:0]   req_size = '0;
    logic [ADDR_W-1:0]   req_address = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    logic [ADDR_W-1:0]   res_address;
    logic [1:0]          res_status;
    logic                res_moved;
    logic [SIZE_W-1:0]   res_copy_bytes;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    t_limit              cfg_data = '0;

    int                  outstanding;
    int                  failures;

    // Idling knobs: chance 1 in N per item (sender) or per cycle (receiver).
    int                  sender_gap_odds = 0;
    int                  stall_odds = 0;
    int                  stall_left = 0;

    // Data addresses seen in results, for well-formed free and reallocate.
    logic [ADDR_W-1:0]   known_addr [MAX_BLOCKS];
    int                  n_known = 0;

    first_fit_block_allocator dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (req_valid),
        .o_ready       (req_ready),
        .i_kind        (req_kind),
        .i_size        (req_size),
        .i_address     (req_address),
        .o_valid       (res_valid),
        .i_ready       (res_ready),
        .o_address_res (res_address),
        .o_status      (res_status),
        .o_moved       (res_moved),
        .o_copy_bytes  (res_copy_bytes),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    ffba_heap_tracker tracker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_req_valid      (req_valid),
        .i_req_ready      (req_ready),
        .i_req_kind       (req_kind),
        .i_req_size       (req_size),
        .i_req_address    (req_address),
        .i_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .i_res_address    (res_address),
        .i_res_status     (res_status),
        .i_res_moved      (res_moved),
        .i_res_copy_bytes (res_copy_bytes),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .o_outstanding    (outstanding),
        .o_failures       (failures)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Result side: start a stall burst at random, else stay ready.
    always @(posedge clk) begin
        if (stall_left == 0 && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left = $urandom_range(1, 15);
        end
        if (stall_left != 0) begin
            res_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            res_ready <= 1'b1;
        end
    end

    // Collect every new data address handed out; blocks never leave the table.
    always @(posedge clk) begin : learn_addresses
        bit seen;
        seen = 1'b0;
        if (rst_n && res_valid && res_ready && res_address != 0 && n_known < MAX_BLOCKS) begin
            for (int i = 0; i < n_known; i++) begin
                if (known_addr[i] == res_address) begin
                    seen = 1'b1;
                end
            end
            if (!seen) begin
                known_addr[n_known] <= res_address;
                n_known <= n_known + 1;
            end
        end
    end

    // Present one item and hold it until accepted; optionally idle first.
    task automatic push_request(input t_kind kind, input logic [SIZE_W-1:0] size,
                                input logic [ADDR_W-1:0] addr);
        if (sender_gap_odds != 0 && $urandom_range(1, sender_gap_odds) == 1) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_valid   <= 1'b1;
        req_kind    <= kind;
        req_size    <= size;
        req_address <= addr;
        do @(posedge clk); while (!req_ready);
    endtask

    // Drop valid and wait until every result is back and the block is idle.
    task automatic hold_until_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0 || !req_ready);
    endtask

    task automatic write_limit(input t_limit limit);
        hold_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small payloads so the table fills before the heap does.
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return '0;
        end else if (r < 9) begin
            return SIZE_W'($urandom());
        end else if (r < 80) begin
            return SIZE_W'($urandom_range(1, 512));
        end
        return SIZE_W'($urandom_range(513, 4096));
    endfunction

    // Mostly live blocks; the rest null, near misses and noise.
    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70 && n_known > 0) begin
            return known_addr[$urandom_range(0, n_known - 1)];
        end else if (r < 78) begin
            return '0;
        end else if (r < 88 && n_known > 0) begin
            return known_addr[$urandom_range(0, n_known - 1)]
                 + ADDR_W'($urandom_range(1, 3));
        end
        return ADDR_W'($urandom());
    endfunction

    // Send items until the given number of non-ignored ones went out.
    task automatic run_random(input int items);
        int    sent;
        int    r;
        t_kind kind;
        sent = 0;
        while (sent < items) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                kind = KIND_ALLOC;
            end else if (r < 75) begin
                kind = KIND_FREE;
            end else if (r < 95) begin
                kind = KIND_REALLOC;
            end else begin
                kind = KIND_IGNORE;
            end
            push_request(kind, pick_size(), pick_address());
            if (kind != KIND_IGNORE) begin
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling.
        // Zero limit: nothing can grow.
        write_limit('0);
        push_request(KIND_ALLOC, SIZE_W'(1), '0);
        // Limit exactly at the first block's end: one fits, the next does not.
        write_limit(t_limit'(HEADER_BYTES + 1));
        push_request(KIND_ALLOC, SIZE_W'(1), '0);
        push_request(KIND_ALLOC, SIZE_W'(1), '0);
        // All-ones limit saturates at the address space.
        write_limit('1);
        push_request(KIND_ALLOC, '1, '0);
        push_request(KIND_ALLOC, '0, '1);
        push_request(KIND_ALLOC, SIZE_W'(100), '0);
        push_request(KIND_FREE, '0, '0);
        push_request(KIND_FREE, '1, FIRST_DATA);
        push_request(KIND_FREE, '0, FIRST_DATA);
        push_request(KIND_FREE, '0, '1);
        push_request(KIND_ALLOC, SIZE_W'(1), '0);
        push_request(KIND_ALLOC, SIZE_W'(200), '0);
        push_request(KIND_FREE, '0, SECOND_DATA);
        push_request(KIND_ALLOC, SIZE_W'(50), '0);
        push_request(KIND_REALLOC, SIZE_W'(10), '0);
        push_request(KIND_REALLOC, '0, SECOND_DATA);
        push_request(KIND_REALLOC, SIZE_W'(100), SECOND_DATA);
        push_request(KIND_REALLOC, SIZE_W'(500), SECOND_DATA);
        push_request(KIND_REALLOC, '1, FIRST_DATA);
        push_request(KIND_REALLOC, SIZE_W'(5), 20'h12345);
        push_request(KIND_IGNORE, '1, '1);

        // Tight heap: growth fails on the limit before the table fills.
        sender_gap_odds = 4;
        stall_odds <= 10;
        write_limit(t_limit'(30000));
        run_random(100);
        hold_until_drained();
        run_random(100);

        // Reset-value limit, with a stretch of back-to-back traffic.
        write_limit(LIMIT_RST);
        run_random(50);
        sender_gap_odds = 0;
        stall_odds <= 0;
        run_random(50);
        sender_gap_odds = 4;
        stall_odds <= 10;
        run_random(50);

        // Limit above the address space, then none at all.
        write_limit('1);
        run_random(60);
        write_limit('0);
        run_random(40);

        // Final stretch: random limit, no idling.
        sender_gap_odds = 0;
        stall_odds <= 0;
        write_limit(t_limit'($urandom_range(0, LIMIT_RST)));
        run_random(60);

        hold_until_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
